/* sv/moving_average_level_meter_unit_assert.svh */
// assertion macros for the moving average level meter checker
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef MOVING_AVERAGE_LEVEL_METER_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_LEVEL_METER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MAVG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mavg_pkg.sv */
// shared types and constants for the moving average level meter
// no dependencies
package mavg_pkg;

    localparam int WINDOW_LOG2_DEFAULT = 4;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    localparam int LIMIT_BITS     = 10;
    localparam int LEVEL_BITS     = 3;
    localparam int INDICATOR_BITS = 5;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [LIMIT_BITS-1:0]     limit_t;
    typedef logic [LEVEL_BITS-1:0]     level_t;
    typedef logic [INDICATOR_BITS-1:0] indicator_t;

    localparam limit_t LEVEL_ONE_RESET   = limit_t'(200);
    localparam limit_t LEVEL_TWO_RESET   = limit_t'(400);
    localparam limit_t LEVEL_THREE_RESET = limit_t'(600);
    localparam limit_t LEVEL_FOUR_RESET  = limit_t'(800);

    localparam level_t LEVEL_ZERO  = level_t'(0);
    localparam level_t LEVEL_ONE   = level_t'(1);
    localparam level_t LEVEL_TWO   = level_t'(2);
    localparam level_t LEVEL_THREE = level_t'(3);
    localparam level_t LEVEL_FOUR  = level_t'(4);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LEVEL_ONE   = 2'd0,
        REG_LEVEL_TWO   = 2'd1,
        REG_LEVEL_THREE = 2'd2,
        REG_LEVEL_FOUR  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        limit_t one;
        limit_t two;
        limit_t three;
        limit_t four;
    } limits_t;

    typedef struct packed {
        level_t     level;
        indicator_t indicator;
    } band_t;

endpackage

/* sv/mavg_band.sv */
// band classifier: maps a window mean onto level 0..4 and a one-hot lamp pattern
// depends on mavg_pkg
module mavg_band #(
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic [SAMPLE_BITS-1:0] mean,
    input  mavg_pkg::limits_t      limits,
    output mavg_pkg::band_t        band
);

    localparam int CMP_BITS = (SAMPLE_BITS > mavg_pkg::LIMIT_BITS) ?
                              SAMPLE_BITS : mavg_pkg::LIMIT_BITS;

    logic [CMP_BITS-1:0] mean_ext;
    mavg_pkg::level_t    level;

    assign mean_ext = CMP_BITS'(mean);

    // first limit not exceeded wins, so unordered limits still resolve
    always_comb
    begin
        if (mean_ext <= CMP_BITS'(limits.one))
            level = mavg_pkg::LEVEL_ZERO;
        else if (mean_ext <= CMP_BITS'(limits.two))
            level = mavg_pkg::LEVEL_ONE;
        else if (mean_ext <= CMP_BITS'(limits.three))
            level = mavg_pkg::LEVEL_TWO;
        else if (mean_ext <= CMP_BITS'(limits.four))
            level = mavg_pkg::LEVEL_THREE;
        else
            level = mavg_pkg::LEVEL_FOUR;
    end

    always_comb
    begin
        band.level = level;
        case (level)
            mavg_pkg::LEVEL_ZERO:  band.indicator = mavg_pkg::indicator_t'(5'b00001);
            mavg_pkg::LEVEL_ONE:   band.indicator = mavg_pkg::indicator_t'(5'b00010);
            mavg_pkg::LEVEL_TWO:   band.indicator = mavg_pkg::indicator_t'(5'b00100);
            mavg_pkg::LEVEL_THREE: band.indicator = mavg_pkg::indicator_t'(5'b01000);
            default:               band.indicator = mavg_pkg::indicator_t'(5'b10000);
        endcase
    end

endmodule

/* sv/moving_average_level_meter_unit.sv */
// moving average level meter: top level with sample ring, running sum and output register
// depends on mavg_pkg and mavg_band
//
// usage
// - input channel (in_valid/in_ready, sample): one converter reading per transaction
// - output channel (out_valid/out_ready, mean_value, level, indicator): one result
//   per transaction once the window is full
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes one of the
//   four level limits; cfg_ready is always high, write only while the block is idle
// - the first 2^WINDOW_LOG2 - 1 samples after reset only fill the ring; every later
//   sample gives one result. warm-up happens once and never returns
// - an accepted sample passes the input stage and then the result register
// - throughput: one sample per cycle unless the receiver stalls; one input stage
//   feeds one result register, and the running sum updates in one add-subtract
// - reset clears the control state, the running sum, the fill count and the
//   limits (200/400/600/800); ring entries not yet written read as zero through
//   the fill count, so no clearing pass is needed
// - when the receiver stalls, the result register holds, the input stage fills,
//   and in_ready drops until out_ready returns
module moving_average_level_meter_unit #(
    parameter int WINDOW_LOG2 = mavg_pkg::WINDOW_LOG2_DEFAULT,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              sample,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SAMPLE_BITS-1:0]              mean_value,
    output mavg_pkg::level_t                    level,
    output mavg_pkg::indicator_t                indicator,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mavg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  mavg_pkg::limit_t                    cfg_data
);

    localparam int WINDOW_SIZE = 1 << WINDOW_LOG2;
    localparam int SUM_BITS    = SAMPLE_BITS + WINDOW_LOG2;
    localparam int FILL_BITS   = WINDOW_LOG2 + 1;

    localparam logic [WINDOW_LOG2-1:0] SLOT_START = WINDOW_LOG2'(1);
    localparam logic [FILL_BITS-1:0]   FILL_FULL  = FILL_BITS'(WINDOW_SIZE);
    localparam logic [FILL_BITS-1:0]   FILL_LAST  = FILL_BITS'(WINDOW_SIZE - 1);

    // sample ring, no reset: entries are overwritten before they count
    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_SIZE];

    // write pointer and fill count, advanced per accepted transaction
    logic [WINDOW_LOG2-1:0] slot_reg, slot_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;

    // input stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SAMPLE_BITS-1:0] s1_old_reg;
    logic [WINDOW_LOG2-1:0] s1_slot_reg;
    logic                   s1_fresh_reg;
    logic                   s1_emit_reg;

    // running sum
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] old_value;
    logic [SAMPLE_BITS-1:0] mean_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] mean_reg;
    mavg_pkg::band_t        band_reg, band_next;

    // limit registers
    mavg_pkg::limits_t      limits_reg;

    logic in_fire;
    logic s1_adv;
    logic s1_load_out;

    // a warm-up item never waits on the output side
    assign s1_adv      = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign s1_load_out = s1_adv && s1_emit_reg;
    assign in_ready    = !s1_valid_reg || s1_adv;
    assign in_fire     = in_valid && in_ready;
    assign cfg_ready   = 1'b1;

    // pointer and fill count
    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (in_fire)
        begin
            slot_next = slot_reg + WINDOW_LOG2'(1);
            if (fill_reg != FILL_FULL)
                fill_next = fill_reg + FILL_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_START;
            fill_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    // ring read at acceptance, write when the item leaves the input stage;
    // the entry read was written by the item one window earlier, long gone
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_old_reg <= ring_mem[slot_reg];
        if (s1_adv)
            ring_mem[s1_slot_reg] <= s1_sample_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= sample;
            s1_slot_reg   <= slot_reg;
            s1_fresh_reg  <= (fill_reg != FILL_FULL);
            s1_emit_reg   <= (fill_reg >= FILL_LAST);
        end
    end

    // slot not yet written since reset reads as zero
    assign old_value = s1_fresh_reg ? '0 : s1_old_reg;

    always_comb
    begin
        sum_next = sum_reg;
        if (s1_adv)
            sum_next = sum_reg + SUM_BITS'(s1_sample_reg) - SUM_BITS'(old_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    assign mean_next = sum_next[SUM_BITS-1:WINDOW_LOG2];

    mavg_band #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_band (
        .mean   (mean_next),
        .limits (limits_reg),
        .band   (band_next)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load_out)
        begin
            mean_reg <= mean_next;
            band_reg <= band_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_value = mean_reg;
    assign level      = band_reg.level;
    assign indicator  = band_reg.indicator;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.one   <= mavg_pkg::LEVEL_ONE_RESET;
            limits_reg.two   <= mavg_pkg::LEVEL_TWO_RESET;
            limits_reg.three <= mavg_pkg::LEVEL_THREE_RESET;
            limits_reg.four  <= mavg_pkg::LEVEL_FOUR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (mavg_pkg::cfg_reg_t'(cfg_index))
                mavg_pkg::REG_LEVEL_ONE:   limits_reg.one   <= cfg_data;
                mavg_pkg::REG_LEVEL_TWO:   limits_reg.two   <= cfg_data;
                mavg_pkg::REG_LEVEL_THREE: limits_reg.three <= cfg_data;
                mavg_pkg::REG_LEVEL_FOUR:  limits_reg.four  <= cfg_data;
                default:                   limits_reg       <= limits_reg;
            endcase
        end
    end

endmodule

/* sv/mavg_checker.sv */
// port-level checker for the moving average level meter, bound to the top level
// depends on mavg_pkg and moving_average_level_meter_unit_assert.svh
`include "moving_average_level_meter_unit_assert.svh"

module mavg_checker #(
    parameter int WINDOW_LOG2 = mavg_pkg::WINDOW_LOG2_DEFAULT,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] mean_value,
    input mavg_pkg::level_t       level,
    input mavg_pkg::indicator_t   indicator
);

    localparam int WINDOW_SIZE = 1 << WINDOW_LOG2;
    localparam int SEEN_BITS   = WINDOW_LOG2 + 1;
    localparam logic [SEEN_BITS-1:0] SEEN_FULL = SEEN_BITS'(WINDOW_SIZE);

    // accepted transactions, saturating at one window
    logic [SEEN_BITS-1:0] seen_reg, seen_next;

    always_comb
    begin
        seen_next = seen_reg;
        if (in_valid && in_ready && seen_reg != SEEN_FULL)
            seen_next = seen_reg + SEEN_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else
            seen_reg <= seen_next;
    end

    // no result before a full window of samples
    `MAVG_ASSERT_NOW(a_no_early_result, out_valid, seen_reg == SEEN_FULL, "result during warm-up")

    // a fresh result belongs to an earlier accepted sample
    `MAVG_ASSERT_NOW(a_rise_after_accept, $rose(out_valid), $past(in_valid && in_ready, 2), "result without sample")

    // lamp pattern agrees with the level
    `MAVG_ASSERT_NOW(a_lamp_matches_level, out_valid, (level == mavg_pkg::LEVEL_ZERO && indicator == 5'b00001) || (level == mavg_pkg::LEVEL_ONE && indicator == 5'b00010) || (level == mavg_pkg::LEVEL_TWO && indicator == 5'b00100) || (level == mavg_pkg::LEVEL_THREE && indicator == 5'b01000) || (level == mavg_pkg::LEVEL_FOUR && indicator == 5'b10000), "lamp pattern mismatch")

    // stalled result holds
    `MAVG_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(mean_value) && $stable(level) && $stable(indicator), "stalled result changed")

endmodule

bind moving_average_level_meter_unit mavg_checker #(
    .WINDOW_LOG2 (WINDOW_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mavg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_value (mean_value),
    .level      (level),
    .indicator  (indicator)
);
